### hdl/itp_pkg.sv
// itp_pkg: shared types, character codes, error codes and the precedence function
// for the infix to postfix converter. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCH  = 2'd2;

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_LPAR,
    CLS_RPAR,
    CLS_OPER,
    CLS_FLUSH
  } cls_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic [1:0] prec;
  } cmd_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = PREC_NONE;
    priority if (c == CH_POW)                      p = PREC_POW;
    else if (c == CH_MUL || c == CH_DIV)           p = PREC_MUL;
    else if (c == CH_PLUS || c == CH_MINUS)        p = PREC_ADD;
    else                                           p = PREC_NONE;
    return p;
  endfunction

endpackage

### hdl/infix_to_postfix_converter_unit.sv
// Infix to postfix converter (shunting-yard), top level.
// An operator pops each entry of equal or higher precedence down to the nearest '(',
// merging its final pop with its push; ')' pops up to and including its '(' and
// reports an error if unmatched; the end marker pops every stacked entry. Rate is set
// by the back's single stack port: one push or pop per cycle, unless a result is due and the output is stalled.
// Reset (rst_ni low, async): stack empty, queue empty, no result pending.
`timescale 1ns / 1ps

// Structure:
//  - itp_front classifies each character (operand, '(', ')', operator with
//    precedence, end marker) and holds up to two commands, so input stalls
//    only when the queue is full.
//  - itp_back works the queue head: unless a result is due while the output is
//    stalled, each cycle it does one stack step and may load one result into the
//    output register. The stack top is cached in a register so the entry below it
//    can be read in the same cycle, so the back knows if this pop is the item's last.
//  - An operator's final pop swaps it straight into the top slot, saving the
//    separate push step.
//  - The end marker uses a count of stacked operators to flag the last
//    emitted operator while stray '(' entries are dropped silently.
module infix_to_postfix_converter_unit import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  itp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .character_i (character_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  itp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

### hdl/itp_front.sv
// itp_front: accepts input items, classifies each character and queues the
// resulting command in a two-entry queue. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_front import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] character_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_in;

  // Classification
  always_comb begin
    cmd_in.ch   = character_i;
    cmd_in.prec = prec_of(character_i);
    priority if (kind_i)                    cmd_in.cls = CLS_FLUSH;
    else if (character_i == CH_LPAR)        cmd_in.cls = CLS_LPAR;
    else if (character_i == CH_RPAR)        cmd_in.cls = CLS_RPAR;
    else if (cmd_in.prec != PREC_NONE)      cmd_in.cls = CLS_OPER;
    else                                    cmd_in.cls = CLS_OPERAND;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### hdl/itp_back.sv
// itp_back: runs queued commands on the operator stack (one step per cycle unless
// a stalled output holds a result), drives the result register. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_back import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  // Stack with cached top: top_q is the top entry, stack_q holds the rest.
  logic [7:0]       stack_q [STACK_DEPTH];
  logic [7:0]       top_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ops_q, ops_d;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [7:0]       next_top;
  logic             empty, full, have2;
  logic             top_lpar, next_lpar;
  logic [1:0]       top_prec, next_prec;

  logic             do_pop, do_push, do_swap, emit, done, step;
  logic [7:0]       e_char;
  logic [1:0]       e_err;
  logic             e_last;
  logic             out_free;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic [1:0]       out_err_q;
  logic             out_last_q;

  assign cnt_m1    = count_q - CNT_W'(1);
  assign cnt_m2    = count_q - CNT_W'(2);
  assign next_top  = stack_q[cnt_m2[IDX_W-1:0]];
  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(STACK_DEPTH));
  assign have2     = (count_q >= CNT_W'(2));
  assign top_lpar  = (top_q == CH_LPAR);
  assign next_lpar = (next_top == CH_LPAR);
  assign top_prec  = prec_of(top_q);
  assign next_prec = prec_of(next_top);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    do_pop  = 1'b0;
    do_push = 1'b0;
    do_swap = 1'b0;
    emit    = 1'b0;
    done    = 1'b0;
    e_char  = 8'd0;
    e_err   = ERR_NONE;
    e_last  = 1'b0;
    unique case (cmd_i.cls)
      CLS_OPERAND: begin
        emit   = 1'b1;
        e_char = cmd_i.ch;
        e_last = 1'b1;
        done   = 1'b1;
      end
      CLS_LPAR: begin
        done = 1'b1;
        if (full) begin
          emit   = 1'b1;
          e_err  = ERR_OVERFLOW;
          e_last = 1'b1;
        end else begin
          do_push = 1'b1;
        end
      end
      CLS_OPER: begin
        if (!empty && !top_lpar && top_prec >= cmd_i.prec) begin
          emit   = 1'b1;
          e_char = top_q;
          e_last = !(have2 && !next_lpar && next_prec >= cmd_i.prec);
          // Final pop: the incoming operator replaces the popped top
          if (e_last) begin
            do_swap = 1'b1;
            done    = 1'b1;
          end else begin
            do_pop = 1'b1;
          end
        end else if (full) begin
          emit   = 1'b1;
          e_err  = ERR_OVERFLOW;
          e_last = 1'b1;
          done   = 1'b1;
        end else begin
          do_push = 1'b1;
          done    = 1'b1;
        end
      end
      CLS_RPAR: begin
        if (empty) begin
          emit   = 1'b1;
          e_err  = ERR_UNMATCH;
          e_last = 1'b1;
          done   = 1'b1;
        end else if (top_lpar) begin
          do_pop = 1'b1;
          done   = 1'b1;
        end else begin
          do_pop = 1'b1;
          emit   = 1'b1;
          e_char = top_q;
          e_last = have2 && next_lpar;
        end
      end
      CLS_FLUSH: begin
        if (empty) begin
          done = 1'b1;
        end else begin
          do_pop = 1'b1;
          done   = (count_q == CNT_W'(1));
          if (!top_lpar) begin
            emit   = 1'b1;
            e_char = top_q;
            e_last = (ops_q == CNT_W'(1));
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign step      = cmd_valid_i && (!emit || out_free);
  assign cmd_pop_o = step && done;

  always_comb begin
    count_d = count_q;
    ops_d   = ops_q;
    if (step) begin
      if (do_push) begin
        count_d = count_q + CNT_W'(1);
        if (cmd_i.cls == CLS_OPER) ops_d = ops_q + CNT_W'(1);
      end else if (do_pop) begin
        count_d = cnt_m1;
        if (!top_lpar) ops_d = ops_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ops_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ops_q   <= ops_d;
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      if (do_push) begin
        if (!empty) stack_q[cnt_m1[IDX_W-1:0]] <= top_q;
        top_q <= cmd_i.ch;
      end else if (do_swap) begin
        top_q <= cmd_i.ch;
      end else if (do_pop) begin
        top_q <= next_top;
      end
    end
    if (step && emit) begin
      out_char_q <= e_char;
      out_err_q  <= e_err;
      out_last_q <= e_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign error_code_o = out_err_q;
  assign last_o       = out_last_q;

endmodule

### hdl/itp_checker.sv
// itp_checker: port-level assertions for the converter top level, and the
// bind that attaches them. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_checker import itp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic [1:0] error_code_o,
  input logic       last_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o)
      && $stable(error_code_o) && $stable(last_o))
    else $error("stalled result changed");

  a_err_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> out_char_o == 8'd0)
    else $error("error result carries a character");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> last_o)
    else $error("error result not flagged last");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o == ERR_NONE || error_code_o == ERR_OVERFLOW
      || error_code_o == ERR_UNMATCH)
    else $error("undefined error code");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (.*);

### sim/infix_to_postfix_converter_unit_test.sv
// Self-checking testbench for infix_to_postfix_converter_unit.
// Depends on itp_pkg (character and error codes, stack depth) and the unit itself.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_test;
  import itp_pkg::*;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Cycles with no item moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 180;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] err;
    logic       is_last;
  } postfix_t;

  // Directed row: typed rows carry their expected result count (0 or 1)
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n_res;
    logic [7:0] res_char;
    logic [1:0] res_err;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       kind_i;
  logic [7:0] character_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic [1:0] error_code_o;
  logic       last_o;

  infix_to_postfix_converter_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .character_i  (character_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: operator stack and its fill
  logic [7:0] op_stk [STACK_DEPTH];
  int         op_depth;

  postfix_t postfix_q[$];  // expected results, oldest first
  postfix_t step_q[$];     // results predicted for the current item
  row_t     rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int quiet_cycles;
  int items_sent;
  int results_seen;
  int overflow_seen;
  int unmatch_seen;
  int most_results;

  logic [7:0] op_chars [5];

  function automatic int op_rank(input logic [7:0] c);
    case (c)
      CH_POW:          return 3;
      CH_MUL, CH_DIV:  return 2;
      CH_PLUS, CH_MINUS: return 1;
      default:         return 0;
    endcase
  endfunction

  function automatic bit is_special(input logic [7:0] c);
    return (c == CH_LPAR) || (c == CH_RPAR) || (op_rank(c) != 0);
  endfunction

  task automatic put_result(input logic [7:0] c, input logic [1:0] e);
    postfix_t r;
    r.out_char = c;
    r.err      = e;
    r.is_last  = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic push_op(input logic [7:0] c);
    if (op_depth >= STACK_DEPTH) begin
      put_result(8'h00, ERR_OVERFLOW);
    end else begin
      op_stk[op_depth] = c;
      op_depth++;
    end
  endtask

  // Shunting-yard step: fills step_q with the results one item causes
  task automatic predict_step(input logic k, input logic [7:0] c);
    logic [7:0] top;
    bit         matched;
    bit         done;
    int         rank;
    step_q.delete();
    if (k == KIND_END) begin
      while (op_depth > 0) begin
        op_depth--;
        top = op_stk[op_depth];
        if (top != CH_LPAR) put_result(top, ERR_NONE);
      end
    end else if (c == CH_LPAR) begin
      push_op(c);
    end else if (c == CH_RPAR) begin
      matched = 1'b0;
      while (op_depth > 0 && !matched) begin
        op_depth--;
        top = op_stk[op_depth];
        if (top == CH_LPAR) matched = 1'b1;
        else put_result(top, ERR_NONE);
      end
      if (!matched) put_result(8'h00, ERR_UNMATCH);
    end else if (op_rank(c) != 0) begin
      rank = op_rank(c);
      done = 1'b0;
      while (op_depth > 0 && !done) begin
        top = op_stk[op_depth - 1];
        if (top == CH_LPAR || op_rank(top) < rank) begin
          done = 1'b1;
        end else begin
          op_depth--;
          put_result(top, ERR_NONE);
        end
      end
      push_op(c);
    end else begin
      put_result(c, ERR_NONE);
    end
  endtask

  // Drive one item, wait for its handshake, then queue what it should produce.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_item(input logic k, input logic [7:0] c, input bit typed,
                           input int tn, input logic [7:0] tch, input logic [1:0] terr);
    postfix_t r;
    int       i;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    character_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_step(k, c);
    if (typed) begin
      if (tn == 1) begin
        r.out_char = tch;
        r.err      = terr;
        r.is_last  = 1'b1;
        postfix_q.push_back(r);
      end
    end else begin
      for (i = 0; i < step_q.size(); i++) begin
        r = step_q[i];
        r.is_last = (i == step_q.size() - 1);
        postfix_q.push_back(r);
      end
    end
    for (i = 0; i < step_q.size(); i++) begin
      if (step_q[i].err == ERR_OVERFLOW) overflow_seen++;
      if (step_q[i].err == ERR_UNMATCH) unmatch_seen++;
    end
    if (step_q.size() > most_results) most_results = step_q.size();
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(KIND_CHAR, c, 1'b0, 0, 8'h00, ERR_NONE);
  endtask

  task automatic send_end();
    send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b0, 0, 8'h00, ERR_NONE);
  endtask

  // Sender holds off until every queued result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h61, 8'h7A));
    c = 8'($urandom_range(0, 255));
    while (is_special(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_op();
    return op_chars[$urandom_range(0, 4)];
  endfunction

  // Balanced-ish expression with random content, closed by an end marker
  task automatic well_formed_expr();
    int nest;
    int ops;
    int limit;
    bit want_operand;
    bit stop;
    nest = 0;
    ops = 0;
    limit = $urandom_range(1, 10);
    want_operand = 1'b1;
    stop = 1'b0;
    while (!stop) begin
      if (want_operand) begin
        if (nest < 6 && $urandom_range(0, 3) == 0) begin
          send_char(CH_LPAR);
          nest++;
        end else begin
          send_char(pick_operand());
          want_operand = 1'b0;
        end
      end else if (ops >= limit) begin
        stop = 1'b1;
      end else if (nest > 0 && $urandom_range(0, 2) == 0) begin
        send_char(CH_RPAR);
        nest--;
      end else begin
        send_char(pick_op());
        ops++;
        want_operand = 1'b1;
      end
    end
    // Usually close everything; sometimes leave '(' for the flush to drop
    while (nest > 0 && $urandom_range(0, 4) != 0) begin
      send_char(CH_RPAR);
      nest--;
    end
    send_end();
  endtask

  // Nest up to or past the stack depth so pushes may overflow, then unwind
  task automatic deep_nest();
    int n;
    int i;
    n = $urandom_range(30, 36);
    for (i = 0; i < n; i++) begin
      send_char(CH_LPAR);
      if ($urandom_range(0, 3) == 0) send_char(pick_op());
    end
    send_char(pick_op());
    send_char(pick_operand());
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) send_char(CH_RPAR);
    send_end();
  endtask

  // Unstructured items: stray parentheses, operators, any byte, odd end markers
  task automatic noise_burst();
    int n;
    int i;
    logic [7:0] c;
    n = $urandom_range(3, 8);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 2))
          0:       c = CH_RPAR;
          1:       c = CH_LPAR;
          default: c = pick_op();
        endcase
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      send_item(($urandom_range(0, 9) == 0) ? KIND_END : KIND_CHAR, c,
                1'b0, 0, 8'h00, ERR_NONE);
    end
  endtask

  task automatic add_row(input logic k, input logic [7:0] c, input bit typed,
                         input int n, input logic [7:0] ech, input logic [1:0] eerr);
    row_t r;
    r.kind     = k;
    r.ch       = c;
    r.typed    = typed;
    r.n_res    = 2'(n);
    r.res_char = ech;
    r.res_err  = eerr;
    rows.push_back(r);
  endtask

  // Receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result checker and progress counter
  always @(posedge clk_i) begin
    postfix_t want;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (postfix_q.size() == 0) begin
        $error("result with nothing expected: out_char=%02h error_code=%0d last=%0b",
               out_char_o, error_code_o, last_o);
        fail_count++;
      end else begin
        want = postfix_q.pop_front();
        if (out_char_o !== want.out_char) begin
          $error("out_char: expected %02h, got %02h", want.out_char, out_char_o);
          fail_count++;
        end
        if (error_code_o !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, error_code_o);
          fail_count++;
        end
        if (last_o !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("timeout: no item moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, postfix_q.size());
    $display("FAIL infix_to_postfix_converter_unit");
    $finish;
  end

  initial begin
    int i;
    int phase;
    int target;
    fail_count     = 0;
    quiet_cycles   = 0;
    items_sent     = 0;
    results_seen   = 0;
    overflow_seen  = 0;
    unmatch_seen   = 0;
    most_results   = 0;
    op_depth       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    op_chars[0] = CH_PLUS;
    op_chars[1] = CH_MINUS;
    op_chars[2] = CH_MUL;
    op_chars[3] = CH_DIV;
    op_chars[4] = CH_POW;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_CHAR;
    character_i <= 8'h00;
    out_stall_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-stack corners, operand extremes, precedence, parentheses
    add_row(KIND_CHAR, CH_RPAR, 1'b1, 1, 8'h00, ERR_UNMATCH);  // ')' on empty stack
    add_row(KIND_END,  8'h00,   1'b1, 0, 8'h00, ERR_NONE);     // flush of empty stack
    add_row(KIND_CHAR, 8'h00,   1'b1, 1, 8'h00, ERR_NONE);     // zero byte is an operand
    add_row(KIND_CHAR, 8'hFF,   1'b1, 1, 8'hFF, ERR_NONE);
    add_row(KIND_CHAR, "#",     1'b1, 1, "#",   ERR_NONE);
    add_row(KIND_CHAR, "a",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_PLUS, 1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, "b",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_MUL,  1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, "c",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_POW,  1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, "d",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_MINUS, 1'b0, 0, 8'h00, ERR_NONE);    // pops ^ * +
    add_row(KIND_CHAR, CH_LPAR, 1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, "e",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_DIV,  1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, "f",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_RPAR, 1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_LPAR, 1'b0, 0, 8'h00, ERR_NONE);     // left open
    add_row(KIND_END,  CH_RPAR, 1'b0, 0, 8'h00, ERR_NONE);     // char ignored, '(' dropped
    add_row(KIND_CHAR, CH_LPAR, 1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_RPAR, 1'b0, 0, 8'h00, ERR_NONE);     // direct match, no result
    add_row(KIND_CHAR, "g",     1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_PLUS, 1'b0, 0, 8'h00, ERR_NONE);
    add_row(KIND_CHAR, CH_RPAR, 1'b0, 0, 8'h00, ERR_NONE);     // pops '+', then unmatched
    for (i = 0; i < rows.size(); i++) begin
      send_item(rows[i].kind, rows[i].ch, rows[i].typed, int'(rows[i].n_res),
                rows[i].res_char, rows[i].res_err);
    end
    drain();

    // Random: four handshake phases, sender waits for an empty pipe between them
    target = items_sent;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      target += RANDOM_ITEMS / 4;
      if (phase == 1) deep_nest();
      while (items_sent < target) begin
        case ($urandom_range(0, 19))
          0, 1:          deep_nest();
          2, 3, 4, 5, 6: noise_burst();
          default:       well_formed_expr();
        endcase
      end
      drain();
    end

    in_valid_i <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d items, checked %0d results (%0d overflow, %0d unmatched ')').",
             items_sent, results_seen, overflow_seen, unmatch_seen);
    $display("Largest burst from one item: %0d results; four stall/idle phases.",
             most_results);
    if (fail_count == 0) begin
      $display("PASS infix_to_postfix_converter_unit");
    end else begin
      $display("FAIL infix_to_postfix_converter_unit");
    end
    $finish;
  end

endmodule
